// File: rtl/core/etf_pkg.sv
// Shared constants and types for the escape-time fractal iterator.
// Used by etf_mul64, escape_time_fractal_iterator_core, the checker and the testbench; no dependencies.
package etf_pkg;

  localparam int DATA_W          = 64;
  localparam int PROD_W          = 2 * DATA_W;
  localparam int HALF_W          = DATA_W / 2;
  localparam int ITER_W          = 16;
  localparam int PIX_W           = 8;
  localparam int VIEW_SIZE       = 256;
  localparam int HALF_VIEW_SHIFT = 7;
  localparam int FRAC_BITS_DEF   = 60;
  localparam int VAR_W           = 4;
  localparam int ZOOM_W          = 6;
  localparam int ADDR_W          = 6;
  localparam int REG_IDX_LSB     = 3;

  localparam logic [ITER_W-1:0] MAX_ITER_RST = 16'd5184;

  typedef enum logic [VAR_W-1:0] {
    VAR_MANDELBROT      = 4'd0,
    VAR_TRICORN         = 4'd1,
    VAR_ABS_BOTH        = 4'd2,
    VAR_ABS_IM          = 4'd3,
    VAR_ABS_RE_CONJ     = 4'd4,
    VAR_FOLD_RE         = 4'd5,
    VAR_FOLD_RE_CONJ    = 4'd6,
    VAR_FOLD_BOTH       = 4'd7,
    VAR_ABS_IM_FOLD_RE  = 4'd8,
    VAR_ABS_RE_FOLD_CONJ = 4'd9
  } variety_t;

  typedef enum logic [2:0] {
    REG_VARIETY   = 3'd0,
    REG_CENTER_RE = 3'd1,
    REG_CENTER_IM = 3'd2,
    REG_ZOOM      = 3'd3,
    REG_MAX_ITER  = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_X_GO,
    ST_X_WAIT,
    ST_FOLD,
    ST_ADJ,
    ST_SUM,
    ST_SR_GO,
    ST_SR_WAIT,
    ST_SI_GO,
    ST_SI_WAIT,
    ST_TEST,
    ST_FINISH
  } state_t;

endpackage

// File: rtl/core/etf_mul64.sv
// Iterative 64x64 unsigned multiplier built on one registered 32x32 multiplier.
// Four partial products, full 128-bit result; depends on etf_pkg.
module etf_mul64
  import etf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] a,
  input  logic [DATA_W-1:0] b,
  output logic              busy,
  output logic              done,
  output logic [PROD_W-1:0] prod
);

  logic [DATA_W-1:0] a_r;
  logic [DATA_W-1:0] b_r;
  logic [DATA_W-1:0] pp_r;
  logic [DATA_W-1:0] pp_nxt;
  logic [1:0]        psel_r;
  logic [PROD_W-1:0] acc_r;
  logic [PROD_W-1:0] pp_sh;
  logic [PROD_W-1:0] pp_ext;
  logic [2:0]        cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [HALF_W-1:0] ah;
  logic [HALF_W-1:0] bh;

  always_comb begin
    ah     = cnt_r[1] ? a_r[DATA_W-1:HALF_W] : a_r[HALF_W-1:0];
    bh     = cnt_r[0] ? b_r[DATA_W-1:HALF_W] : b_r[HALF_W-1:0];
    pp_nxt = ah * bh;
    pp_ext = PROD_W'(pp_r);
    case (psel_r)
      2'b00:   pp_sh = pp_ext;
      2'b11:   pp_sh = pp_ext << DATA_W;
      default: pp_sh = pp_ext << HALF_W;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == 3'd4);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd4) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      if (cnt_r < 3'd4) begin
        pp_r   <= pp_nxt;
        psel_r <= cnt_r[1:0];
      end
      if (cnt_r != 3'd0) begin
        acc_r <= acc_r + pp_sh;
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign prod = acc_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("multiply started while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("done held longer than one cycle");

  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r == 3'd4 && !start) |=> (done_r && !busy_r))
    else $error("multiply did not finish after last partial product");

endmodule

// File: rtl/core/escape_time_fractal_iterator_core.sv
// Escape-time fractal iterator: maps a pixel to a point c and iterates one of ten
// formulas in signed fixed point. Depends on etf_pkg and etf_mul64.
//
// Input channel: in_valid/in_stall carry one item, a pixel (in_pixel_x, in_pixel_y)
// of a 256x256 view. Output channel: out_valid/out_stall carry one item per input,
// out_iteration_count, the zero-based escape iteration or max_iterations.
// Configuration: APB-style port, 64-bit data, register i at byte address 8*i
// (variety, center_real, center_imag, zoom_shift, max_iterations).
// The block takes one item at a time; in_stall is high from acceptance until the
// result is handed to the output register. Each iteration computes three
// 64x64 products (z.re*z.im, z.re^2, z.im^2) in turn on the shared
// 32x32 multiplier, plus fold, adjust, sum and escape test steps.
// An escape caught at the bound check returns earlier in its iteration, before
// the two squares are formed.
// The output register holds a finished result while out_stall is high; the block
// accepts the next item meanwhile and waits before its own result if the register
// is still full. Synchronous reset clears the sequencer, output valid and loads
// the register reset values (max_iterations 5184, all others 0).
module escape_time_fractal_iterator_core
  import etf_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [PIX_W-1:0]  in_pixel_x,
  input  logic [PIX_W-1:0]  in_pixel_y,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ITER_W-1:0] out_iteration_count,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam logic signed [DATA_W-1:0] TWO_FX     = DATA_W'(2) << FRAC_BITS;
  localparam logic signed [DATA_W-1:0] NEG_TWO_FX = -TWO_FX;
  localparam logic [DATA_W-1:0]        FOUR_FX    = DATA_W'(4) << FRAC_BITS;
  localparam logic [7:0]               BASE_SH    = 8'(FRAC_BITS - HALF_VIEW_SHIFT);

  // configuration registers
  logic [VAR_W-1:0]         variety_r;
  logic signed [DATA_W-1:0] center_re_r;
  logic signed [DATA_W-1:0] center_im_r;
  logic [ZOOM_W-1:0]        zoom_r;
  logic [ITER_W-1:0]        max_iter_r;
  logic                     cfg_we;
  reg_idx_t                 reg_idx;

  // sequencer and datapath
  state_t                   state_r, state_nxt;
  logic [PIX_W-1:0]         px_r;
  logic [PIX_W-1:0]         py_r;
  logic signed [DATA_W-1:0] c_re_r, c_re_nxt;
  logic signed [DATA_W-1:0] c_im_r, c_im_nxt;
  logic signed [DATA_W-1:0] re_r, re_nxt;
  logic signed [DATA_W-1:0] im_r, im_nxt;
  logic [DATA_W-1:0]        sr_r, sr_nxt;
  logic [DATA_W-1:0]        si_r, si_nxt;
  logic signed [DATA_W-1:0] nr_r, nr_nxt;
  logic signed [DATA_W-1:0] ni_r, ni_nxt;
  logic [ITER_W-1:0]        iter_r, iter_nxt;
  logic [ITER_W-1:0]        res_r, res_nxt;
  logic                     out_valid_r;
  logic [ITER_W-1:0]        out_count_r;
  logic                     out_load;
  logic                     in_accept;

  // formula decode
  variety_t var_e;
  logic     abs_re_in, abs_im_in, neg_im_in, fold_re, fold_im, conj_out;

  // helpers
  logic [DATA_W-1:0]        re_mag, im_mag;
  logic                     re_neg, im_neg, x_neg, x_rem;
  logic [DATA_W-1:0]        x_q;
  logic signed [7:0]        sh;
  logic [5:0]               nsh;
  logic signed [9:0]        dx, dy;
  logic signed [DATA_W-1:0] dx_ext, dy_ext, off_x, off_y;
  logic signed [DATA_W-1:0] re_s, im_s;
  logic                     ovf_re, ovf_im, out_of_box;
  logic [DATA_W-1:0]        sq_sum;
  logic [ITER_W:0]          iter_inc;

  // shared multiplier
  logic                     mul_start, mul_busy, mul_done;
  logic [DATA_W-1:0]        mul_a, mul_b;
  logic [PROD_W-1:0]        mul_prod;

  etf_mul64 u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:REG_IDX_LSB]);
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variety_r   <= VAR_MANDELBROT;
      center_re_r <= '0;
      center_im_r <= '0;
      zoom_r      <= '0;
      max_iter_r  <= MAX_ITER_RST;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_VARIETY:   variety_r   <= pwdata[VAR_W-1:0];
        REG_CENTER_RE: center_re_r <= pwdata;
        REG_CENTER_IM: center_im_r <= pwdata;
        REG_ZOOM:      zoom_r      <= pwdata[ZOOM_W-1:0];
        REG_MAX_ITER:  max_iter_r  <= pwdata[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_VARIETY:   prdata = DATA_W'(variety_r);
      REG_CENTER_RE: prdata = center_re_r;
      REG_CENTER_IM: prdata = center_im_r;
      REG_ZOOM:      prdata = DATA_W'(zoom_r);
      REG_MAX_ITER:  prdata = DATA_W'(max_iter_r);
      default:       prdata = '0;
    endcase
  end

  // formula decode; unused codes run the plain set
  always_comb begin
    var_e     = (variety_r > VAR_ABS_RE_FOLD_CONJ) ? VAR_MANDELBROT : variety_t'(variety_r);
    abs_re_in = 1'b0;
    abs_im_in = 1'b0;
    neg_im_in = 1'b0;
    fold_re   = 1'b0;
    fold_im   = 1'b0;
    conj_out  = 1'b0;
    unique case (var_e)
      VAR_MANDELBROT: ;
      VAR_TRICORN:    conj_out = 1'b1;
      VAR_ABS_BOTH: begin
        abs_re_in = 1'b1;
        abs_im_in = 1'b1;
      end
      VAR_ABS_IM:     abs_im_in = 1'b1;
      VAR_ABS_RE_CONJ: begin
        abs_re_in = 1'b1;
        neg_im_in = 1'b1;
      end
      VAR_FOLD_RE:    fold_re = 1'b1;
      VAR_FOLD_RE_CONJ: begin
        fold_re  = 1'b1;
        conj_out = 1'b1;
      end
      VAR_FOLD_BOTH: begin
        fold_re = 1'b1;
        fold_im = 1'b1;
      end
      VAR_ABS_IM_FOLD_RE: begin
        abs_im_in = 1'b1;
        fold_re   = 1'b1;
      end
      VAR_ABS_RE_FOLD_CONJ: begin
        abs_re_in = 1'b1;
        fold_re   = 1'b1;
        conj_out  = 1'b1;
      end
      default: ;
    endcase
  end

  // operand magnitudes and cross-product sign after the input folds
  always_comb begin
    re_mag = re_r[DATA_W-1] ? DATA_W'(-re_r) : DATA_W'(re_r);
    im_mag = im_r[DATA_W-1] ? DATA_W'(-im_r) : DATA_W'(im_r);
    re_neg = !abs_re_in && re_r[DATA_W-1];
    if (abs_im_in) begin
      im_neg = 1'b0;
    end else if (neg_im_in) begin
      im_neg = !im_r[DATA_W-1] && (im_r != '0);
    end else begin
      im_neg = im_r[DATA_W-1];
    end
    x_neg = re_neg ^ im_neg;
    x_q   = mul_prod[FRAC_BITS+DATA_W-2 -: DATA_W];
    x_rem = |mul_prod[FRAC_BITS-2:0];
  end

  // pixel to point c
  always_comb begin
    dx     = signed'({1'b0, px_r, 1'b0}) - 10'(VIEW_SIZE - 1);
    dy     = 10'(VIEW_SIZE - 1) - signed'({1'b0, py_r, 1'b0});
    dx_ext = DATA_W'(dx);
    dy_ext = DATA_W'(dy);
    sh     = signed'(BASE_SH - {2'b00, zoom_r});
    nsh    = 6'(-sh);
    off_x  = sh[7] ? (dx_ext >>> nsh) : (dx_ext << sh[5:0]);
    off_y  = sh[7] ? (dy_ext >>> nsh) : (dy_ext << sh[5:0]);
  end

  // sum, overflow and bound checks
  always_comb begin
    re_s   = nr_r + c_re_r;
    im_s   = ni_r + c_im_r;
    ovf_re = (nr_r[DATA_W-1] == c_re_r[DATA_W-1]) && (re_s[DATA_W-1] != nr_r[DATA_W-1]);
    ovf_im = (ni_r[DATA_W-1] == c_im_r[DATA_W-1]) && (im_s[DATA_W-1] != ni_r[DATA_W-1]);
    out_of_box = (re_s > TWO_FX) || (re_s < NEG_TWO_FX) ||
                 (im_s > TWO_FX) || (im_s < NEG_TWO_FX);
    sq_sum   = sr_r + si_r;
    iter_inc = {1'b0, iter_r} + 17'd1;
  end

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    c_re_nxt  = c_re_r;
    c_im_nxt  = c_im_r;
    re_nxt    = re_r;
    im_nxt    = im_r;
    sr_nxt    = sr_r;
    si_nxt    = si_r;
    nr_nxt    = nr_r;
    ni_nxt    = ni_r;
    iter_nxt  = iter_r;
    res_nxt   = res_r;
    mul_start = 1'b0;
    mul_a     = re_mag;
    mul_b     = im_mag;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        c_re_nxt = center_re_r + off_x;
        c_im_nxt = center_im_r + off_y;
        re_nxt   = '0;
        im_nxt   = '0;
        sr_nxt   = '0;
        si_nxt   = '0;
        iter_nxt = '0;
        if (max_iter_r == '0) begin
          res_nxt   = max_iter_r;
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_X_GO;
        end
      end
      ST_X_GO: begin
        mul_start = 1'b1;
        state_nxt = ST_X_WAIT;
      end
      ST_X_WAIT: begin
        if (mul_done) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        // squares do not change under abs/negate, so last test's squares serve
        nr_nxt    = sr_r - si_r;
        ni_nxt    = (x_neg ? ~x_q : x_q) + DATA_W'(x_neg && !x_rem);
        state_nxt = ST_ADJ;
      end
      ST_ADJ: begin
        nr_nxt    = (fold_re && nr_r[DATA_W-1]) ? -nr_r : nr_r;
        ni_nxt    = ((fold_im && ni_r[DATA_W-1]) || conj_out) ? -ni_r : ni_r;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        if (ovf_re || ovf_im || out_of_box) begin
          res_nxt   = iter_r;
          state_nxt = ST_FINISH;
        end else begin
          re_nxt    = re_s;
          im_nxt    = im_s;
          state_nxt = ST_SR_GO;
        end
      end
      ST_SR_GO: begin
        mul_start = 1'b1;
        mul_a     = re_mag;
        mul_b     = re_mag;
        state_nxt = ST_SR_WAIT;
      end
      ST_SR_WAIT: begin
        if (mul_done) begin
          sr_nxt    = mul_prod[FRAC_BITS+DATA_W-1 -: DATA_W];
          state_nxt = ST_SI_GO;
        end
      end
      ST_SI_GO: begin
        mul_start = 1'b1;
        mul_a     = im_mag;
        mul_b     = im_mag;
        state_nxt = ST_SI_WAIT;
      end
      ST_SI_WAIT: begin
        if (mul_done) begin
          si_nxt    = mul_prod[FRAC_BITS+DATA_W-1 -: DATA_W];
          state_nxt = ST_TEST;
        end
      end
      ST_TEST: begin
        if (sq_sum > FOUR_FX) begin
          res_nxt   = iter_r;
          state_nxt = ST_FINISH;
        end else if (iter_inc == {1'b0, max_iter_r}) begin
          res_nxt   = max_iter_r;
          state_nxt = ST_FINISH;
        end else begin
          iter_nxt  = iter_inc[ITER_W-1:0];
          state_nxt = ST_X_GO;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      px_r <= in_pixel_x;
      py_r <= in_pixel_y;
    end
    if (out_load) begin
      out_count_r <= res_r;
    end
    c_re_r <= c_re_nxt;
    c_im_r <= c_im_nxt;
    re_r   <= re_nxt;
    im_r   <= im_nxt;
    sr_r   <= sr_nxt;
    si_r   <= si_nxt;
    nr_r   <= nr_nxt;
    ni_r   <= ni_nxt;
    iter_r <= iter_nxt;
    res_r  <= res_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_iteration_count = out_count_r;

  a_accept_setup: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == ST_SETUP))
    else $error("accepted item did not start setup");

  a_iter_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_X_GO) |-> (iter_r < max_iter_r))
    else $error("iteration started at or past the limit");

  a_result_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_count_r <= max_iter_r))
    else $error("result exceeds max_iterations");

  a_finish_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && out_valid_r && out_stall) |=>
      (state_r == ST_FINISH && out_valid_r))
    else $error("result overwrote a stalled output item");

  a_mul_free: assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |-> !mul_busy)
    else $error("product requested while multiplier busy");

endmodule

// File: sim/escape_time_fractal_iterator_checker.sv
// Checker for escape_time_fractal_iterator_core: mirrors register writes, predicts the
// escape iteration of each accepted pixel item and compares it with the returned item.
// Depends on etf_pkg.
module escape_time_fractal_iterator_checker
  import etf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [PIX_W-1:0]  in_pixel_x,
  input  logic [PIX_W-1:0]  in_pixel_y,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [ITER_W-1:0] out_iteration_count,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int                mismatches,
  output int                outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam logic signed [DATA_W-1:0] TWO  = 64'sd2 <<< FRAC;
  localparam logic [DATA_W-1:0]        FOUR = 64'd4 << FRAC;

  typedef struct packed {
    logic [PIX_W-1:0]  x;
    logic [PIX_W-1:0]  y;
    logic [ITER_W-1:0] count;
  } pixel_count_t;

  logic [VAR_W-1:0]         variety;
  logic signed [DATA_W-1:0] center_re;
  logic signed [DATA_W-1:0] center_im;
  logic [ZOOM_W-1:0]        zoom;
  logic [ITER_W-1:0]        iter_limit;
  pixel_count_t             pending_counts[$];
  pixel_count_t             entry;

  // floor(a*b / 2^sh) from the full product
  function automatic logic signed [DATA_W-1:0] fx_mul(input logic signed [DATA_W-1:0] a,
                                                      input logic signed [DATA_W-1:0] b,
                                                      input int sh);
    logic signed [PROD_W-1:0] p;
    p = a * b;
    p = p >>> sh;
    return p[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] magnitude(input logic signed [DATA_W-1:0] a);
    return a[DATA_W-1] ? -a : a;
  endfunction

  // pixel steps scaled to Q4.60, floored when the shift goes negative
  function automatic logic [DATA_W-1:0] view_offset(input int steps,
                                                    input logic [ZOOM_W-1:0] z);
    logic signed [PROD_W-1:0] w;
    int sh;
    w  = steps;
    sh = FRAC - HALF_VIEW_SHIFT - int'(z);
    if (sh >= 0) begin
      w = w <<< sh;
    end else begin
      w = w >>> (-sh);
    end
    return w[DATA_W-1:0];
  endfunction

  function automatic logic [ITER_W-1:0] escape_iteration(input logic [PIX_W-1:0] px,
                                                         input logic [PIX_W-1:0] py);
    logic signed [DATA_W-1:0] c_re, c_im, re, im, nr, ni, sum_re, sum_im, sr, si;
    logic [VAR_W-1:0]         v;
    logic [ITER_W-1:0]        result;
    c_re   = center_re + view_offset(2 * int'(px) - (VIEW_SIZE - 1), zoom);
    c_im   = center_im + view_offset((VIEW_SIZE - 1) - 2 * int'(py), zoom);
    v      = (variety > VAR_ABS_RE_FOLD_CONJ) ? VAR_MANDELBROT : variety;
    re     = '0;
    im     = '0;
    result = iter_limit;
    for (int n = 0; n < int'(iter_limit); n++) begin
      if (v == VAR_ABS_BOTH || v == VAR_ABS_RE_CONJ || v == VAR_ABS_RE_FOLD_CONJ) begin
        re = magnitude(re);
      end
      if (v == VAR_ABS_BOTH || v == VAR_ABS_IM || v == VAR_ABS_IM_FOLD_RE) begin
        im = magnitude(im);
      end
      if (v == VAR_ABS_RE_CONJ) begin
        im = -im;
      end
      nr = fx_mul(re, re, FRAC) - fx_mul(im, im, FRAC);
      ni = fx_mul(re, im, FRAC - 1);
      if (v >= VAR_FOLD_RE) begin
        nr = magnitude(nr);
      end
      if (v == VAR_FOLD_BOTH) begin
        ni = magnitude(ni);
      end
      if (v == VAR_TRICORN || v == VAR_FOLD_RE_CONJ || v == VAR_ABS_RE_FOLD_CONJ) begin
        ni = -ni;
      end
      sum_re = nr + c_re;
      sum_im = ni + c_im;
      // leaving the number range counts as escaping
      if ((nr[DATA_W-1] == c_re[DATA_W-1] && sum_re[DATA_W-1] != nr[DATA_W-1]) ||
          (ni[DATA_W-1] == c_im[DATA_W-1] && sum_im[DATA_W-1] != ni[DATA_W-1])) begin
        result = ITER_W'(n);
        break;
      end
      re = sum_re;
      im = sum_im;
      if (re > TWO || re < -TWO || im > TWO || im < -TWO) begin
        result = ITER_W'(n);
        break;
      end
      sr = fx_mul(re, re, FRAC);
      si = fx_mul(im, im, FRAC);
      if ($unsigned(sr) + $unsigned(si) > FOUR) begin
        result = ITER_W'(n);
        break;
      end
    end
    return result;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t escape check: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      variety    = VAR_MANDELBROT;
      center_re  = '0;
      center_im  = '0;
      zoom       = '0;
      iter_limit = MAX_ITER_RST;
      mismatches = 0;
      pending_counts.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:REG_IDX_LSB])
          REG_VARIETY:   variety    = pwdata[VAR_W-1:0];
          REG_CENTER_RE: center_re  = pwdata;
          REG_CENTER_IM: center_im  = pwdata;
          REG_ZOOM:      zoom       = pwdata[ZOOM_W-1:0];
          REG_MAX_ITER:  iter_limit = pwdata[ITER_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (pending_counts.size() == 0) begin
          report_mismatch($sformatf("count %0d with no pixel pending", out_iteration_count));
        end else begin
          entry = pending_counts.pop_front();
          if (out_iteration_count !== entry.count) begin
            report_mismatch($sformatf("pixel (%0d,%0d): count %0d, predicted %0d",
                                      entry.x, entry.y, out_iteration_count, entry.count));
          end
        end
      end
      if (in_valid && !in_stall) begin
        entry.x     = in_pixel_x;
        entry.y     = in_pixel_y;
        entry.count = escape_iteration(in_pixel_x, in_pixel_y);
        pending_counts.push_back(entry);
      end
    end
    outstanding <= pending_counts.size();
  end

endmodule

// File: sim/escape_time_fractal_iterator_core_tb.sv
// Testbench top for escape_time_fractal_iterator_core: drives pixel items and register
// writes, stalls the result side at random and gives the verdict.
// Depends on etf_pkg, the core and escape_time_fractal_iterator_checker.
module escape_time_fractal_iterator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import etf_pkg::*;

  localparam int RAND_ITEMS  = 90;
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam logic [DATA_W-1:0] ONE = 64'd1 << FRAC_BITS_DEF;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [PIX_W-1:0]  in_pixel_x;
  logic [PIX_W-1:0]  in_pixel_y;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ITER_W-1:0] out_iteration_count;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              calm;
  int                mismatches;
  int                outstanding;
  int                cycles = 0;

  escape_time_fractal_iterator_core dut (.*);

  escape_time_fractal_iterator_checker escape_check (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("escape_time_fractal_iterator_core_tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= rst_n && !calm && ($urandom_range(99) < 17);
  end

  task automatic send_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y);
    while (!calm && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_pixel_x <= x;
    in_pixel_y <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx) << REG_IDX_LSB;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_view(input logic [VAR_W-1:0] v, input logic [DATA_W-1:0] cre,
                          input logic [DATA_W-1:0] cim, input logic [ZOOM_W-1:0] z,
                          input logic [ITER_W-1:0] lim);
    write_reg(REG_VARIETY, DATA_W'(v));
    write_reg(REG_CENTER_RE, cre);
    write_reg(REG_CENTER_IM, cim);
    write_reg(REG_ZOOM, DATA_W'(z));
    write_reg(REG_MAX_ITER, DATA_W'(lim));
  endtask

  initial begin
    logic [DATA_W-1:0] cre;
    logic [DATA_W-1:0] cim;
    logic [ITER_W-1:0] lim;
    int                burst;
    int                sent;
    int                pick;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_pixel_x = '0;
    in_pixel_y = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    calm       = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset view: corners escape at once, the center runs to the reset limit
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd255, 8'd255);
    send_pixel(8'd128, 8'd128);
    send_pixel(8'd255, 8'd0);
    drain();

    // zero limit
    set_view(VAR_MANDELBROT, '0, '0, '0, '0);
    send_pixel(8'd77, 8'd200);
    drain();

    // unused variety, centers at the range ends so c wraps for (255,255), full limit
    set_view(4'd15, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, '0, 16'hFFFF);
    send_pixel(8'd255, 8'd255);
    send_pixel(8'd0, 8'd0);
    drain();

    // deepest zoom around -2: offsets floor to 0 or -1 ulp
    set_view(VAR_MANDELBROT, -(ONE << 1), '0, 6'd63, 16'd30);
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd255, 8'd0);
    send_pixel(8'd255, 8'd255);
    drain();

    for (int v = 0; v <= 10; v++) begin
      set_view(VAR_W'(v), -(ONE >> 1), ONE >> 2, 6'd1, 16'd40);
      send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)));
      drain();
    end

    sent = 0;
    while (sent < RAND_ITEMS) begin
      burst = $urandom_range(6, 16);
      if ($urandom_range(7) == 0) begin
        cre = {$urandom, $urandom};
        cim = {$urandom, $urandom};
      end else begin
        cre = ({$urandom, $urandom} >> 2) % (5 * (ONE >> 1)) - (ONE << 1);
        cim = ({$urandom, $urandom} >> 2) % (5 * (ONE >> 1)) - 5 * (ONE >> 2);
      end
      pick = $urandom_range(15);
      lim  = (pick == 0) ? 16'($urandom_range(3)) :
             (pick == 1) ? 16'($urandom_range(100, 256)) : 16'($urandom_range(4, 64));
      set_view(4'($urandom_range(15)), cre, cim,
               ($urandom_range(8) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(10)),
               lim);
      for (int i = 0; i < burst; i++) begin
        calm <= (sent >= 40 && sent < 70);
        send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)));
        sent++;
      end
      drain();
    end

    repeat (60) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("escape_time_fractal_iterator_core_tb: clean");
    end else begin
      $display("escape_time_fractal_iterator_core_tb: errors");
    end
    $finish;
  end

endmodule

// File: escape_time_fractal_iterator_core.f
rtl/core/etf_pkg.sv
rtl/core/etf_mul64.sv
rtl/core/escape_time_fractal_iterator_core.sv
sim/escape_time_fractal_iterator_checker.sv
sim/escape_time_fractal_iterator_core_tb.sv
